@@ rtl/yfr_pkg.sv @@
// ----------------------------------------------------------------------------
// yfr_pkg: shared types and constants for the YUV 4:2:0 frame rotator
// Holds the frame geometry limits, the code enums and the structs that
// carry commands from the sequencer to the frame store and the pipeline.
// ----------------------------------------------------------------------------
package yfr_pkg;

   localparam int MaxWidth   = 256;
   localparam int MaxHeight  = 256;
   localparam int MinDim     = 16;
   localparam int StoreDepth = (MaxWidth * MaxHeight * 3) / 2;
   localparam int AddrW      = $clog2(StoreDepth);
   localparam int DimW       = 9;
   localparam int CountW     = 8;

   typedef enum logic [1:0] {
      REG_WIDTH    = 2'd0,
      REG_HEIGHT   = 2'd1,
      REG_ROTATION = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ROT_CW90    = 2'd0,
      ROT_180     = 2'd1,
      ROT_CW270   = 2'd2,
      ROT_INVALID = 2'd3
   } rot_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_ROT    = 2'd1,
      STATUS_NOT_LOADED = 2'd2
   } status_type;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_FETCH = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

   typedef struct packed {
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
   } store_cmd_type;

   typedef struct packed {
      logic       issue;
      status_type status;
      logic       last;
   } rsp_info_type;

   // Clamp a dimension to [16, max] and round down to a multiple of 16.
   function automatic logic [DimW-1:0] fit_dim(input logic [DimW-1:0] v,
                                               input logic [DimW-1:0] maxv);
      logic [DimW-1:0] t;
      t = v;
      if (t < DimW'(MinDim)) t = DimW'(MinDim);
      if (t > maxv) t = maxv;
      t = t & ~DimW'(15);
      if (t < DimW'(MinDim)) t = DimW'(MinDim);
      return t;
   endfunction

endpackage

@@ rtl/yfr_store.sv @@
// ----------------------------------------------------------------------------
// yfr_store: frame byte store
// Single write port and single registered read port over the whole frame.
// ----------------------------------------------------------------------------
module yfr_store (
   input  logic                  clock,
   input  yfr_pkg::store_cmd_type cmd,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [yfr_pkg::StoreDepth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/yfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// yfr_ctrl: configuration registers, load counter and fetch address walker
// Steps the rotated read address incrementally, one item per cycle when an item is accepted.
// ----------------------------------------------------------------------------
module yfr_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [yfr_pkg::DimW-1:0]     csr_wdata,
   input  logic                         item_accept,
   input  logic                         item_kind,
   input  logic [7:0]                   item_pixel,
   output yfr_pkg::store_cmd_type       store_cmd,
   output yfr_pkg::rsp_info_type        rsp_info
);

   localparam int AW = yfr_pkg::AddrW;
   localparam int DW = yfr_pkg::DimW;
   localparam int CW = yfr_pkg::CountW;

   logic [DW-1:0]        w_ff, w_in, h_ff, h_in;
   logic [AW-1:0]        wh_ff, wh_in;
   yfr_pkg::rot_type     rot_ff, rot_in;
   logic [AW-1:0]        load_count_ff, load_count_in;
   logic                 full_ff, full_in;
   yfr_pkg::plane_type   plane_ff, plane_in;
   logic [CW-1:0]        col_ff, col_in, row_ff, row_in;
   logic [AW-1:0]        addr_ff, addr_in, col_start_ff, col_start_in;

   logic [DW-1:0]        fit_val;
   logic [2*DW-1:0]      prod;
   logic [AW-1:0]        total, csize;
   logic [DW-1:0]        pw, ph;
   logic [AW-1:0]        off, psize, pw_ext, pstart, cur, col_cur;
   logic                 row_end, col_end, is_last;

   // Frame geometry
   always_comb begin
      total  = wh_ff + {1'b0, wh_ff[AW-1:1]};
      csize  = {2'b0, wh_ff[AW-1:2]};
      pw     = w_ff;
      ph     = h_ff;
      off    = '0;
      psize  = wh_ff;
      case (plane_ff)
         yfr_pkg::PLANE_Y: begin
            off = '0;
         end
         yfr_pkg::PLANE_U: begin
            pw = {1'b0, w_ff[DW-1:1]}; ph = {1'b0, h_ff[DW-1:1]};
            off = wh_ff; psize = csize;
         end
         default: begin
            pw = {1'b0, w_ff[DW-1:1]}; ph = {1'b0, h_ff[DW-1:1]};
            off = wh_ff + csize; psize = csize;
         end
      endcase
      pw_ext = {{(AW-DW){1'b0}}, pw};
      case (rot_ff)
         yfr_pkg::ROT_CW90:  pstart = off + psize - pw_ext;
         yfr_pkg::ROT_CW270: pstart = off + pw_ext - AW'(1);
         default:            pstart = off + psize - AW'(1);
      endcase
      cur     = (row_ff == '0 && col_ff == '0) ? pstart : addr_ff;
      col_cur = (row_ff == '0) ? cur : col_start_ff;
      row_end = ({1'b0, row_ff} + DW'(1)) >= ph;
      col_end = ({1'b0, col_ff} + DW'(1)) >= pw;
      is_last = (plane_ff == yfr_pkg::PLANE_V) && row_end && col_end;
   end

   // Next state
   always_comb begin
      w_in          = w_ff;
      h_in          = h_ff;
      wh_in         = wh_ff;
      rot_in        = rot_ff;
      load_count_in = load_count_ff;
      full_in       = full_ff;
      plane_in      = plane_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      addr_in       = addr_ff;
      col_start_in  = col_start_ff;
      fit_val       = '0;
      prod          = '0;

      store_cmd         = '0;
      store_cmd.wr_addr = load_count_ff;
      store_cmd.wr_data = item_pixel;
      store_cmd.rd_addr = cur;

      rsp_info        = '0;
      rsp_info.status = yfr_pkg::STATUS_OK;

      if (csr_we) begin
         unique case (yfr_pkg::reg_index_type'(csr_index))
            yfr_pkg::REG_WIDTH: begin
               fit_val = yfr_pkg::fit_dim(csr_wdata, DW'(yfr_pkg::MaxWidth));
               prod    = {{DW{1'b0}}, fit_val} * {{DW{1'b0}}, h_ff};
               w_in    = fit_val;
               wh_in   = prod[AW-1:0];
               load_count_in = '0; full_in = 1'b0;
               plane_in = yfr_pkg::PLANE_Y; col_in = '0; row_in = '0;
            end
            yfr_pkg::REG_HEIGHT: begin
               fit_val = yfr_pkg::fit_dim(csr_wdata, DW'(yfr_pkg::MaxHeight));
               prod    = {{DW{1'b0}}, w_ff} * {{DW{1'b0}}, fit_val};
               h_in    = fit_val;
               wh_in   = prod[AW-1:0];
               load_count_in = '0; full_in = 1'b0;
               plane_in = yfr_pkg::PLANE_Y; col_in = '0; row_in = '0;
            end
            yfr_pkg::REG_ROTATION: begin
               rot_in   = yfr_pkg::rot_type'(csr_wdata[1:0]);
               plane_in = yfr_pkg::PLANE_Y; col_in = '0; row_in = '0;
            end
            default: ;
         endcase
      end else if (item_accept) begin
         if (yfr_pkg::kind_type'(item_kind) == yfr_pkg::KIND_LOAD) begin
            // Drop loads once the frame is complete
            if (!full_ff && load_count_ff < total) begin
               store_cmd.wr_en = 1'b1;
               load_count_in   = load_count_ff + AW'(1);
               full_in         = (load_count_ff + AW'(1)) >= total;
            end
         end else begin
            rsp_info.issue = 1'b1;
            if (rot_ff == yfr_pkg::ROT_INVALID) begin
               rsp_info.status = yfr_pkg::STATUS_BAD_ROT;
            end else if (!full_ff) begin
               rsp_info.status = yfr_pkg::STATUS_NOT_LOADED;
            end else begin
               store_cmd.rd_en = 1'b1;
               rsp_info.last   = is_last;
               if (is_last) begin
                  // Release the frame for the next load
                  load_count_in = '0; full_in = 1'b0;
                  plane_in = yfr_pkg::PLANE_Y; col_in = '0; row_in = '0;
               end else if (!row_end) begin
                  row_in       = row_ff + CW'(1);
                  col_start_in = col_cur;
                  case (rot_ff)
                     yfr_pkg::ROT_CW90:  addr_in = cur - pw_ext;
                     yfr_pkg::ROT_CW270: addr_in = cur + pw_ext;
                     default:            addr_in = cur - AW'(1);
                  endcase
               end else if (!col_end) begin
                  row_in = '0;
                  col_in = col_ff + CW'(1);
                  case (rot_ff)
                     yfr_pkg::ROT_CW90:  addr_in = col_cur + AW'(1);
                     yfr_pkg::ROT_CW270: addr_in = col_cur - AW'(1);
                     default:            addr_in = cur - AW'(1);
                  endcase
               end else begin
                  row_in   = '0;
                  col_in   = '0;
                  plane_in = yfr_pkg::plane_type'(plane_ff + 2'd1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff          <= DW'(yfr_pkg::MaxWidth);
         h_ff          <= DW'(yfr_pkg::MaxHeight);
         wh_ff         <= AW'(yfr_pkg::MaxWidth * yfr_pkg::MaxHeight);
         rot_ff        <= yfr_pkg::ROT_CW90;
         load_count_ff <= '0;
         full_ff       <= 1'b0;
         plane_ff      <= yfr_pkg::PLANE_Y;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         w_ff          <= w_in;
         h_ff          <= h_in;
         wh_ff         <= wh_in;
         rot_ff        <= rot_in;
         load_count_ff <= load_count_in;
         full_ff       <= full_in;
         plane_ff      <= plane_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      col_start_ff <= col_start_in;
   end

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= total)
      else $error("load count ran past the frame size");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> load_count_ff == total)
      else $error("frame marked full with bytes missing");

   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      plane_ff <= yfr_pkg::PLANE_V)
      else $error("fetch plane ran past the V plane");

endmodule

@@ rtl/yuv420_planar_frame_rotate.sv @@
// ----------------------------------------------------------------------------
// yuv420_planar_frame_rotate: rotating frame buffer for planar YUV 4:2:0
// Loads one frame byte by byte, then streams it back rotated 90/180/270.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries items: tuser = kind (0 load, 1 fetch), tdata = source byte.
//   A load writes the next frame byte (Y plane, then U, then V) and gives no
//   result. A fetch gives one result on rsp_*: tdata = rotated byte,
//   tlast = final byte of the frame, tuser = status (ok, invalid rotation,
//   frame not loaded). On error the byte and tlast read as zero.
//   csr_* writes frame_width (0), frame_height (1) and rotation (2) while the
//   block is idle; a dimension write drops the frame, a rotation write
//   restarts the fetch order.
// Throughput: one item per cycle, loads and fetches alike, while req_tready
//   is high. The rotated address is stepped incrementally, and the frame
//   store has one write port and one registered read port, so each fetch
//   costs exactly one read.
// Result path: store read at the accepting edge, then the output register.
// Reset: clears the load count and fetch position and sets a 256x256 frame,
//   90 clockwise. Store contents are not cleared; no warm-up pass is needed.
// Stall: with rsp_tready low the output register holds, the read stage
//   fills, and then req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module yuv420_planar_frame_rotate (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] pixel_in
   input  logic                     req_tuser,   // [0] kind
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,   // [7:0] pixel_out
   output logic                     rsp_tlast,
   output logic [1:0]               rsp_tuser,   // [1:0] status
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [yfr_pkg::DimW-1:0] csr_wdata
);

   yfr_pkg::store_cmd_type store_cmd;
   yfr_pkg::rsp_info_type  rsp_info;
   logic [7:0]             rd_data;

   logic                   item_accept;
   logic                   out_free;
   logic                   s1_valid_ff;
   yfr_pkg::status_type    s1_status_ff;
   logic                   s1_last_ff;
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_data_ff;
   logic                   rsp_last_ff;
   yfr_pkg::status_type    rsp_status_ff;

   // Advance the read stage whenever the output register is empty or draining
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || out_free;
   assign item_accept = req_tvalid && req_tready;

   yfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_accept (item_accept),
      .item_kind   (req_tuser),
      .item_pixel  (req_tdata),
      .store_cmd   (store_cmd),
      .rsp_info    (rsp_info)
   );

   yfr_store u_store (
      .clock   (clock),
      .cmd     (store_cmd),
      .rd_data (rd_data)
   );

   // Read stage: hold status while the store read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rsp_info.issue) begin
         s1_valid_ff <= 1'b1;
      end else if (out_free) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_info.issue) begin
         s1_status_ff <= rsp_info.status;
         s1_last_ff   <= rsp_info.last;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         // Zero the byte on any error status
         rsp_data_ff   <= (s1_status_ff == yfr_pkg::STATUS_OK) ? rd_data : 8'd0;
         rsp_last_ff   <= s1_last_ff;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && s1_valid_ff |-> !req_tready)
      else $error("item taken while both result stages are full");

   a_fetch_tracked: assert property (@(posedge clock) disable iff (reset)
      item_accept && req_tuser |=> s1_valid_ff)
      else $error("accepted fetch lost before the read stage");

   a_last_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_status_ff == yfr_pkg::STATUS_OK)
      else $error("last flag raised on an error result");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      item_accept && !req_tuser && !s1_valid_ff |=> !s1_valid_ff)
      else $error("load produced a result");

endmodule
